### rtl/grpg_pkg.sv
// ----------------------------------------------------------------------------
// grpg_pkg
// Shared constants and types for the grid row permutation generator.
// ----------------------------------------------------------------------------
package grpg_pkg;

   localparam int SYMBOLS_DEFAULT = 9;
   localparam int ROWS_DEFAULT    = 9;
   localparam int WORD_W          = 32;
   localparam int SYM_W           = 4;
   localparam int STEP_W          = $clog2(WORD_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PICK
   } state_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [SYM_W-1:0]  divisor;
   } mod_req_type;

endpackage

### rtl/grpg_mod_unit.sv
// ----------------------------------------------------------------------------
// grpg_mod_unit
// Restoring remainder of a 32-bit word by a 4-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module grpg_mod_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  grpg_pkg::mod_req_type      req,
   output logic                       done,
   output logic [grpg_pkg::SYM_W-1:0] remainder
);

   localparam logic [grpg_pkg::STEP_W-1:0] LAST_STEP =
      grpg_pkg::STEP_W'(grpg_pkg::WORD_W - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [grpg_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [grpg_pkg::WORD_W-1:0]   word_ff, word_in;
   logic [grpg_pkg::SYM_W-1:0]    div_ff, div_in;
   logic [grpg_pkg::SYM_W-1:0]    rem_ff, rem_in;
   logic [grpg_pkg::SYM_W:0]      trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      word_in = word_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, word_ff[grpg_pkg::WORD_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         word_in = req.dividend;
         div_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         word_in = {word_ff[grpg_pkg::WORD_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = grpg_pkg::SYM_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[grpg_pkg::SYM_W-1:0];
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      word_ff <= word_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### rtl/grid_row_permutation_generator_unit.sv
// ----------------------------------------------------------------------------
// grid_row_permutation_generator_unit
// Emits one random permutation of 1..SYMBOLS per grid row, one symbol a beat.
// ----------------------------------------------------------------------------
// Each request beat carries a 32-bit random word; the block answers with one
// response beat: the symbol taken from the row's remaining list at index
// word mod remaining count, with its row, column and end-of-row/end-of-grid
// flags. From request acceptance to response valid, an item goes in steps:
// the remainder unit resolves one dividend bit a cycle, the sequencer sees it
// finish and enters the pick state, then the pick loads the entry into the
// response register. The request side is stalled for that time, so a new
// request is taken only after the previous item is picked; a waiting response
// beat does not block acceptance, only the pick of the following item.
module grid_row_permutation_generator_unit #(
   parameter int SYMBOLS = grpg_pkg::SYMBOLS_DEFAULT,
   parameter int ROWS    = grpg_pkg::ROWS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [grpg_pkg::WORD_W-1:0] req_random_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [grpg_pkg::SYM_W-1:0]  rsp_chosen_symbol,
   output logic [grpg_pkg::SYM_W-1:0]  rsp_row_index,
   output logic [grpg_pkg::SYM_W-1:0]  rsp_column_index,
   output logic                        rsp_row_done,
   output logic                        rsp_grid_done
);

   localparam int IDX_W = $clog2(SYMBOLS);
   localparam logic [grpg_pkg::SYM_W-1:0] SYM_MAX  = grpg_pkg::SYM_W'(SYMBOLS);
   localparam logic [grpg_pkg::SYM_W-1:0] ROW_LAST = grpg_pkg::SYM_W'(ROWS - 1);

   grpg_pkg::state_type state_ff, state_in;

   logic [grpg_pkg::SYM_W-1:0] list_ff [SYMBOLS];
   logic [grpg_pkg::SYM_W-1:0] list_in [SYMBOLS];
   logic [grpg_pkg::SYM_W-1:0] count_ff, count_in;
   logic [grpg_pkg::SYM_W-1:0] row_ff, row_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [grpg_pkg::SYM_W-1:0] sym_ff, sym_in;
   logic [grpg_pkg::SYM_W-1:0] orow_ff, orow_in;
   logic [grpg_pkg::SYM_W-1:0] col_ff, col_in;
   logic                       rdone_ff, rdone_in;
   logic                       gdone_ff, gdone_in;

   logic                       accept;
   logic                       emit;
   logic                       count_bad;
   logic [grpg_pkg::SYM_W-1:0] count_fix;
   logic [grpg_pkg::SYM_W-1:0] count_dec;
   logic [IDX_W-1:0]           idx;
   logic                       out_free;

   grpg_pkg::mod_req_type      mod_req;
   logic                       mod_done;
   logic [grpg_pkg::SYM_W-1:0] mod_rem;

   grpg_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .req       (mod_req),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign count_bad = (count_ff == '0) || (count_ff > SYM_MAX);
   assign count_fix = count_bad ? SYM_MAX : count_ff;
   assign count_dec = count_ff - 1'b1;
   assign idx       = mod_rem[IDX_W-1:0];
   assign out_free  = !(rsp_valid_ff && rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         grpg_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = grpg_pkg::ST_DIVIDE;
            end
         end
         grpg_pkg::ST_DIVIDE: begin
            if (mod_done) begin
               state_in = grpg_pkg::ST_PICK;
            end
         end
         grpg_pkg::ST_PICK: begin
            if (out_free) begin
               state_in = grpg_pkg::ST_IDLE;
            end
         end
         default: state_in = grpg_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      emit      = 1'b0;
      case (state_ff)
         grpg_pkg::ST_IDLE:   req_stall = 1'b0;
         grpg_pkg::ST_DIVIDE: req_stall = 1'b1;
         grpg_pkg::ST_PICK:   emit      = out_free;
         default:             req_stall = 1'b1;
      endcase
   end

   assign accept           = req_valid && !req_stall;
   assign mod_req.start    = accept;
   assign mod_req.dividend = req_random_word;
   assign mod_req.divisor  = count_fix;

   // datapath
   always_comb begin
      count_in     = count_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sym_in       = sym_ff;
      orow_in      = orow_ff;
      col_in       = col_ff;
      rdone_in     = rdone_ff;
      gdone_in     = gdone_ff;
      for (int i = 0; i < SYMBOLS; i++) begin
         list_in[i] = list_ff[i];
      end
      if (accept) begin
         count_in = count_fix;
         if (count_bad) begin
            for (int i = 0; i < SYMBOLS; i++) begin
               list_in[i] = grpg_pkg::SYM_W'(i + 1);
            end
         end
         if (row_ff > ROW_LAST) begin
            row_in = '0;
         end
      end else if (emit) begin
         rsp_valid_in = 1'b1;
         sym_in       = list_ff[idx];
         orow_in      = row_ff;
         col_in       = SYM_MAX - count_ff;
         rdone_in     = (count_dec == '0);
         gdone_in     = (count_dec == '0) && (row_ff == ROW_LAST);
         if (count_dec == '0) begin
            count_in = SYM_MAX;
            row_in   = (row_ff >= ROW_LAST) ? '0 : row_ff + 1'b1;
            for (int i = 0; i < SYMBOLS; i++) begin
               list_in[i] = grpg_pkg::SYM_W'(i + 1);
            end
         end else begin
            count_in = count_dec;
            for (int i = 0; i < SYMBOLS - 1; i++) begin
               if (IDX_W'(i) >= idx) begin
                  list_in[i] = list_ff[i + 1];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= grpg_pkg::ST_IDLE;
         count_ff     <= SYM_MAX;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SYMBOLS; i++) begin
            list_ff[i] <= grpg_pkg::SYM_W'(i + 1);
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < SYMBOLS; i++) begin
            list_ff[i] <= list_in[i];
         end
      end
      sym_ff   <= sym_in;
      orow_ff  <= orow_in;
      col_ff   <= col_in;
      rdone_ff <= rdone_in;
      gdone_ff <= gdone_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_symbol = sym_ff;
   assign rsp_row_index     = orow_ff;
   assign rsp_column_index  = col_ff;
   assign rsp_row_done      = rdone_ff;
   assign rsp_grid_done     = gdone_ff;

endmodule
